### rtl/dimmer_with_press_classifier_assert.svh
// Assertion macros for the dimmer with press classifier.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef DIMMER_WITH_PRESS_CLASSIFIER_ASSERT_SVH
`define DIMMER_WITH_PRESS_CLASSIFIER_ASSERT_SVH

// Check a property outside reset
`define DWPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");

// Check a property at every clock edge, reset included
`define DWPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

### rtl/dwpc_pkg.sv
// Shared types and constants of the dimmer with press classifier.
// No dependencies; used by the top level and the press classifier.
package dwpc_pkg;

  localparam int TIME_W = 16;
  localparam int IDX_W  = 4;
  localparam int DUTY_W = 8;

  typedef logic [TIME_W-1:0] ms_t;

  // Register map of the configuration channel
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] CFG_RETRIGGER = 2'd1;
  localparam logic [1:0] CFG_LONG      = 2'd2;
  localparam logic [1:0] CFG_LOCKOUT   = 2'd3;

  // Configuration values after reset
  localparam ms_t DEBOUNCE_RESET  = 16'd50;
  localparam ms_t RETRIGGER_RESET = 16'd200;
  localparam ms_t LONG_RESET      = 16'd1500;
  localparam ms_t LOCKOUT_RESET   = 16'd1000;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_SHORT = 2'd1,
    CLASS_LONG  = 2'd2
  } press_class_t;

  typedef enum logic [1:0] {
    KEY_ONOFF = 2'd0,
    KEY_UP    = 2'd1,
    KEY_DIM   = 2'd2,
    KEY_OTHER = 2'd3
  } key_code_t;

  // Operating mode, one-hot
  typedef enum logic [3:0] {
    MODE_NORMAL      = 4'b0001,
    MODE_LEARN_POWER = 4'b0010,
    MODE_LEARN_UP    = 4'b0100,
    MODE_LEARN_DOWN  = 4'b1000
  } mode_t;

  // Mode numbers as they appear on the result word
  localparam logic [1:0] MODE_CODE_NORMAL      = 2'd0;
  localparam logic [1:0] MODE_CODE_LEARN_POWER = 2'd1;
  localparam logic [1:0] MODE_CODE_LEARN_UP    = 2'd2;
  localparam logic [1:0] MODE_CODE_LEARN_DOWN  = 2'd3;

  // Thresholds handed to the press classifier
  typedef struct packed {
    ms_t debounce;
    ms_t retrigger;
    ms_t long_press;
  } press_cfg_t;

  // Brightness table; entries past the tenth run at full drive
  localparam logic [DUTY_W-1:0] DUTY_TABLE [16] = '{
    8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd96, 8'd128, 8'd160,
    8'd192, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  // Saturating millisecond count
  function automatic ms_t sat_inc(input ms_t v);
    return (v == '1) ? v : v + ms_t'(1);
  endfunction

endpackage

### rtl/dwpc_press.sv
// Button press classifier: tracks the previous pin level and the time since
// the last press start. Depends on dwpc_pkg.
module dwpc_press
  import dwpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,  // one tick is processed this cycle
  input  logic         level,    // 0 pressed, 1 released
  input  press_cfg_t   cfg,
  output press_class_t cls
);

  logic button_prev;
  ms_t  since_press_start;
  ms_t  since_press_start_next;
  logic press_start;
  logic press_end;

  // Advance the held-time counter, restart it on an accepted press start, classify a release
  always_comb begin
    since_press_start_next = sat_inc(since_press_start);
    press_start = !level && button_prev && (since_press_start_next > cfg.retrigger);
    if (press_start) begin
      since_press_start_next = '0;
    end
    press_end = level && !button_prev && (since_press_start_next > cfg.debounce);
    if (!press_end) begin
      cls = CLASS_NONE;
    end else if (since_press_start_next <= cfg.long_press) begin
      cls = CLASS_SHORT;
    end else begin
      cls = CLASS_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_prev       <= 1'b1;
      since_press_start <= '0;
    end else if (advance) begin
      button_prev       <= level;
      since_press_start <= since_press_start_next;
    end
  end

endmodule

### rtl/dimmer_with_press_classifier.sv
// Channel  Dir  Word                      Contents
// s_*      in   s_tdata  [7:0]            one millisecond tick
// m_*      out  m_tdata  [23:0]           result of that tick
// cfg_*    in   cfg_index, cfg_data       threshold register write
//
// One tick is taken every cycle unless m_tready holds the result; each tick
// passes input register, then result register. The path between them is one
// 16-bit increment and compare plus the brightness table lookup.
// Reset clears both valid bits and all state and restores the default
// thresholds. A low m_tready holds the result; one more tick waits in the
// input register, after which s_tready drops. Configuration is always ready.
//
// Top level of the dimmer with press classifier.
// Depends on dwpc_pkg and dwpc_press.
module dimmer_with_press_classifier
  import dwpc_pkg::*;
#(
  parameter int LEVEL_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] button_level, [1] key_valid, [3:2] key_code, [7:4] zero
  input  logic [7:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] pwm_duty, [8] light_on, [12:9] level_index, [14:13] current_mode,
  // [16:15] press_class, [17] save_request, [19:18] save_slot,
  // [20] learn_capture, [21] learn_clear, [23:22] zero
  output logic [23:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [IDX_W-1:0] TOP_INDEX   = IDX_W'(LEVEL_COUNT - 1);
  localparam logic [IDX_W-1:0] RESET_INDEX =
    (LEVEL_COUNT > 2) ? IDX_W'(2) : IDX_W'(LEVEL_COUNT - 1);

  // Threshold registers
  ms_t debounce_ms, retrigger_ms, long_press_ms, power_lockout_ms;

  // Input register
  logic      in_valid;
  logic      in_level;
  logic      in_kvalid;
  key_code_t in_kcode;

  // Tick state
  ms_t              since_power_toggle, since_power_toggle_next;
  logic             power_state, power_state_next;
  logic [IDX_W-1:0] brightness_index, brightness_index_next;
  mode_t            mode_state, mode_state_next;

  logic         out_free;
  logic         advance;
  press_cfg_t   press_cfg;
  press_class_t cls;
  logic         save;
  logic [1:0]   slot;
  logic         capture;
  logic         clear;
  logic [1:0]   mode_code, mode_code_next;
  logic [23:0]  m_tdata_next;

  assign out_free  = !m_tvalid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;
  assign cfg_ready = 1'b1;

  // Write threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= DEBOUNCE_RESET;
      retrigger_ms     <= RETRIGGER_RESET;
      long_press_ms    <= LONG_RESET;
      power_lockout_ms <= LOCKOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  debounce_ms      <= cfg_data;
        CFG_RETRIGGER: retrigger_ms     <= cfg_data;
        CFG_LONG:      long_press_ms    <= cfg_data;
        CFG_LOCKOUT:   power_lockout_ms <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level  <= s_tdata[0];
      in_kvalid <= s_tdata[1];
      in_kcode  <= key_code_t'(s_tdata[3:2]);
    end
  end

  assign press_cfg = '{debounce: debounce_ms, retrigger: retrigger_ms,
                       long_press: long_press_ms};

  dwpc_press u_press (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .level   (in_level),
    .cfg     (press_cfg),
    .cls     (cls)
  );

  // Encode the current mode and step to the next one
  always_comb begin
    unique case (mode_state)
      MODE_NORMAL:      mode_code = MODE_CODE_NORMAL;
      MODE_LEARN_POWER: mode_code = MODE_CODE_LEARN_POWER;
      MODE_LEARN_UP:    mode_code = MODE_CODE_LEARN_UP;
      MODE_LEARN_DOWN:  mode_code = MODE_CODE_LEARN_DOWN;
      default:          mode_code = MODE_CODE_NORMAL;
    endcase
  end

  always_comb begin
    save  = (cls == CLASS_LONG) && (mode_state != MODE_NORMAL);
    slot  = save ? (mode_code - 2'd1) : 2'd0;
    clear = (cls != CLASS_NONE);
    mode_state_next = mode_state;
    mode_code_next  = mode_code;
    if (clear) begin
      unique case (mode_state)
        MODE_NORMAL: begin
          mode_state_next = MODE_LEARN_POWER;
          mode_code_next  = MODE_CODE_LEARN_POWER;
        end
        MODE_LEARN_POWER: begin
          mode_state_next = MODE_LEARN_UP;
          mode_code_next  = MODE_CODE_LEARN_UP;
        end
        MODE_LEARN_UP: begin
          mode_state_next = MODE_LEARN_DOWN;
          mode_code_next  = MODE_CODE_LEARN_DOWN;
        end
        default: begin
          mode_state_next = MODE_NORMAL;
          mode_code_next  = MODE_CODE_NORMAL;
        end
      endcase
    end
  end

  // Act on the remote key in the mode as updated this tick
  always_comb begin
    since_power_toggle_next = sat_inc(since_power_toggle);
    power_state_next        = power_state;
    brightness_index_next   = brightness_index;
    capture                 = 1'b0;
    if (in_kvalid) begin
      if (mode_state_next != MODE_NORMAL) begin
        capture = 1'b1;
      end else begin
        case (in_kcode)
          KEY_ONOFF: begin
            if (since_power_toggle_next > power_lockout_ms) begin
              power_state_next        = !power_state;
              since_power_toggle_next = '0;
            end
          end
          KEY_UP: begin
            if (!power_state || brightness_index >= TOP_INDEX) begin
              brightness_index_next = TOP_INDEX;
            end else begin
              brightness_index_next = brightness_index + IDX_W'(1);
            end
            power_state_next = 1'b1;
          end
          KEY_DIM: begin
            if (!power_state) begin
              brightness_index_next = '0;
            end else if (brightness_index != '0) begin
              brightness_index_next = brightness_index - IDX_W'(1);
            end
            power_state_next = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Pack the result word
  always_comb begin
    m_tdata_next = {2'b00, clear, capture, slot, save, cls, mode_code_next,
                    brightness_index_next, power_state_next,
                    power_state_next ? DUTY_TABLE[brightness_index_next] : 8'd0};
  end

  // Advance tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      since_power_toggle <= '0;
      power_state        <= 1'b0;
      brightness_index   <= RESET_INDEX;
      mode_state         <= MODE_NORMAL;
    end else if (advance) begin
      since_power_toggle <= since_power_toggle_next;
      power_state        <= power_state_next;
      brightness_index   <= brightness_index_next;
      mode_state         <= mode_state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

### rtl/dwpc_checker.sv
// Port-level checks on the result channel of the dimmer with press classifier.
// Uses dimmer_with_press_classifier_assert.svh; bound to the top level below.
`include "dimmer_with_press_classifier_assert.svh"

module dwpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled result word stays put
  `DWPC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // Nothing is offered straight after reset
  `DWPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid)

  // Drive is zero exactly when the light is off
  `DWPC_ASSERT(a_duty_light, m_tvalid |-> ((m_tdata[7:0] == 8'd0) == !m_tdata[8]))

  // A save request only comes with a long press
  `DWPC_ASSERT(a_save_long, m_tvalid && m_tdata[17] |-> m_tdata[16:15] == 2'd2)

  // Every classified press raises learn_clear, and no other result does
  `DWPC_ASSERT(a_clear_press, m_tvalid |-> (m_tdata[21] == (m_tdata[16:15] != 2'd0)))

endmodule

bind dimmer_with_press_classifier dwpc_checker u_dwpc_checker (.*);
